// ===== src/ost_pkg.sv =====
`timescale 1ns / 1ps
// ost_pkg: request and response word types, operation and status codes
// for the ordered stack table. No dependencies.
package ost_pkg;

	localparam int ITEM_W      = 32;
	localparam int POS_W       = 4;
	localparam int OP_W        = 2;
	localparam int STATUS_W    = 2;
	localparam int COUNT_OUT_W = 5;

	localparam logic [OP_W-1:0] OP_PUSH   = 2'd0;
	localparam logic [OP_W-1:0] OP_REMOVE = 2'd1;
	localparam logic [OP_W-1:0] OP_INSERT = 2'd2;

	localparam logic [STATUS_W-1:0] ST_OK        = 2'd0;
	localparam logic [STATUS_W-1:0] ST_NOT_FOUND = 2'd1;
	localparam logic [STATUS_W-1:0] ST_FULL      = 2'd2;
	localparam logic [STATUS_W-1:0] ST_BAD_POS   = 2'd3;

	typedef struct packed {
		logic [OP_W-1:0]   req_type;
		logic [ITEM_W-1:0] item_value;
		logic [POS_W-1:0]  position;
	} req_t;

	typedef struct packed {
		logic [STATUS_W-1:0]    status;
		logic [ITEM_W-1:0]      item_out;
		logic [COUNT_OUT_W-1:0] count_out;
	} rsp_t;

endpackage

// ===== src/ost_ram.sv =====
`timescale 1ns / 1ps
// ost_ram: generic single-write, single-read RAM with registered read data.
// No dependencies.
module ost_ram #(
	parameter int WIDTH = 32,
	parameter int DEPTH = 16
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		rdata <= mem[raddr];
	end

endmodule

// ===== src/ost_seq.sv =====
`timescale 1ns / 1ps
// ost_seq: sequencer for the ordered stack table; fill count, scan and move
// pointers, the shared word comparator and the response register. Uses ost_pkg.
module ost_seq #(
	parameter int DEPTH      = 16,
	parameter int WORD_WIDTH = 32
) (
	input  logic                      clk,
	input  logic                      arst_n,
	input  logic                      start,
	input  logic [ost_pkg::OP_W-1:0]  req_type,
	input  logic [WORD_WIDTH-1:0]     word,
	input  logic [ost_pkg::POS_W-1:0] position,
	output logic                      busy,
	input  logic [WORD_WIDTH-1:0]     rd_data,
	output logic                      ram_we,
	output logic [$clog2(DEPTH)-1:0]  ram_waddr,
	output logic [WORD_WIDTH-1:0]     ram_wdata,
	output logic [$clog2(DEPTH)-1:0]  ram_raddr,
	output logic                      done,
	output ost_pkg::rsp_t             rsp
);
	import ost_pkg::*;

	localparam int AW   = $clog2(DEPTH);
	localparam int CW   = $clog2(DEPTH + 1);
	localparam int CMPW = (CW > POS_W) ? CW : POS_W;

	localparam logic [1:0] S_IDLE     = 2'd0;
	localparam logic [1:0] S_DISPATCH = 2'd1;
	localparam logic [1:0] S_REMOVE   = 2'd2;
	localparam logic [1:0] S_INSERT   = 2'd3;

	logic [1:0]          state_q, state_d;
	logic [CW-1:0]       count_q, count_d;
	logic [CW-1:0]       rd_ptr_q, rd_ptr_d;
	logic [AW-1:0]       ins_ptr_q, ins_ptr_d;
	logic [AW-1:0]       pend_addr_q, pend_addr_d;
	logic                pend_q, pend_d;
	logic                found_q, found_d;
	logic                iss_q, iss_d;
	logic                done_q;
	logic [OP_W-1:0]     op_q;
	logic [WORD_WIDTH-1:0] word_q;
	logic [POS_W-1:0]    pos_q;
	rsp_t                rsp_q;
	logic                match;
	logic                rm_issue;
	logic                fin;
	logic [STATUS_W-1:0] fin_st;

	// the one comparator, reused for every entry scanned
	assign match    = (rd_data == word_q);
	assign rm_issue = (rd_ptr_q < count_q);

	always_comb begin
		state_d     = state_q;
		count_d     = count_q;
		rd_ptr_d    = rd_ptr_q;
		ins_ptr_d   = ins_ptr_q;
		pend_addr_d = pend_addr_q;
		pend_d      = 1'b0;
		found_d     = found_q;
		iss_d       = iss_q;
		fin         = 1'b0;
		fin_st      = ST_OK;
		ram_we      = 1'b0;
		ram_waddr   = '0;
		ram_wdata   = rd_data;
		ram_raddr   = '0;
		case (state_q)
			S_IDLE: begin
				if (start) begin
					state_d = S_DISPATCH;
				end
			end
			S_DISPATCH: begin
				case (op_q)
					OP_PUSH: begin
						fin = 1'b1;
						if (count_q == CW'(DEPTH)) begin
							fin_st = ST_FULL;
						end else begin
							ram_we    = 1'b1;
							ram_waddr = count_q[AW-1:0];
							ram_wdata = word_q;
							count_d   = count_q + CW'(1);
						end
					end
					OP_REMOVE: begin
						if (count_q == '0) begin
							fin    = 1'b1;
							fin_st = ST_NOT_FOUND;
						end else begin
							state_d  = S_REMOVE;
							rd_ptr_d = '0;
							found_d  = 1'b0;
						end
					end
					OP_INSERT: begin
						if (CMPW'(pos_q) >= CMPW'(count_q)) begin
							fin    = 1'b1;
							fin_st = ST_BAD_POS;
						end else if (count_q == CW'(DEPTH)) begin
							fin    = 1'b1;
							fin_st = ST_FULL;
						end else begin
							state_d   = S_INSERT;
							ins_ptr_d = AW'(count_q - CW'(1));
							iss_d     = 1'b1;
						end
					end
					default: begin
						fin    = 1'b1;
						fin_st = ST_BAD_POS;
					end
				endcase
			end
			S_REMOVE: begin
				// read runs one entry ahead of the compare and the move down
				ram_raddr = rd_ptr_q[AW-1:0];
				if (rm_issue) begin
					rd_ptr_d    = rd_ptr_q + CW'(1);
					pend_d      = 1'b1;
					pend_addr_d = rd_ptr_q[AW-1:0];
				end
				if (pend_q) begin
					if (found_q) begin
						ram_we    = 1'b1;
						ram_waddr = pend_addr_q - AW'(1);
					end else if (match) begin
						found_d = 1'b1;
					end
					if (!rm_issue) begin
						fin = 1'b1;
						if (found_q || match) begin
							count_d = count_q - CW'(1);
						end else begin
							fin_st = ST_NOT_FOUND;
						end
					end
				end
			end
			S_INSERT: begin
				// walk down from the top, each word moves up one place
				ram_raddr = ins_ptr_q;
				if (iss_q) begin
					pend_d      = 1'b1;
					pend_addr_d = ins_ptr_q;
					if (CMPW'(ins_ptr_q) == CMPW'(pos_q)) begin
						iss_d = 1'b0;
					end else begin
						ins_ptr_d = ins_ptr_q - AW'(1);
					end
				end
				if (pend_q) begin
					ram_we    = 1'b1;
					ram_waddr = pend_addr_q + AW'(1);
				end else if (!iss_q) begin
					ram_we    = 1'b1;
					ram_waddr = AW'(pos_q);
					ram_wdata = word_q;
					count_d   = count_q + CW'(1);
					fin       = 1'b1;
				end
			end
			default: begin
				state_d = S_IDLE;
			end
		endcase
		if (fin) begin
			state_d = S_IDLE;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_IDLE;
			count_q     <= '0;
			rd_ptr_q    <= '0;
			ins_ptr_q   <= '0;
			pend_addr_q <= '0;
			pend_q      <= 1'b0;
			found_q     <= 1'b0;
			iss_q       <= 1'b0;
			done_q      <= 1'b0;
		end else begin
			state_q     <= state_d;
			count_q     <= count_d;
			rd_ptr_q    <= rd_ptr_d;
			ins_ptr_q   <= ins_ptr_d;
			pend_addr_q <= pend_addr_d;
			pend_q      <= pend_d;
			found_q     <= found_d;
			iss_q       <= iss_d;
			done_q      <= fin;
		end
	end

	always_ff @(posedge clk) begin
		if (state_q == S_IDLE && start) begin
			op_q   <= req_type;
			word_q <= word;
			pos_q  <= position;
		end
		if (fin) begin
			rsp_q.status    <= fin_st;
			rsp_q.item_out  <= (fin_st == ST_OK) ? ITEM_W'(word_q) : '0;
			rsp_q.count_out <= COUNT_OUT_W'(count_d);
		end
	end

	assign busy = (state_q != S_IDLE);
	assign done = done_q;
	assign rsp  = rsp_q;

	a_count_bound: assert property (@(posedge clk) disable iff (!arst_n)
		count_q <= CW'(DEPTH))
		else $error("fill count above depth");

	a_done_after_work: assert property (@(posedge clk) disable iff (!arst_n)
		done_q |-> $past(state_q != S_IDLE))
		else $error("response without an operation in flight");

	a_count_moves_with_done: assert property (@(posedge clk) disable iff (!arst_n)
		(count_q != $past(count_q)) |-> done_q)
		else $error("fill count changed without a response");

	a_write_in_range: assert property (@(posedge clk) disable iff (!arst_n)
		ram_we |-> (CW'(ram_waddr) < CW'(DEPTH)))
		else $error("store write beyond depth");

	a_refusal_clean: assert property (@(posedge clk) disable iff (!arst_n)
		(done_q && rsp_q.status != ST_OK) |->
		(rsp_q.count_out == COUNT_OUT_W'($past(count_q))))
		else $error("refused operation changed the count");

endmodule

// ===== src/ordered_stack_table.sv =====
`timescale 1ns / 1ps
// ordered_stack_table: top level; word sizing, store RAM and sequencer.
// Uses ost_pkg, ost_ram and ost_seq.
//
//   port    dir  word      handshake
//   req     in   req_t     taken at the clock edge with start high, busy low
//   rsp     out  rsp_t     valid for the one cycle that done is high
//
// push, undefined word, refused insert, remove on an empty store: done follows
//   straight from the dispatch state, with no scan or move
// remove otherwise: every held entry is scanned (one entry scanned or moved per cycle)
// insert: entries from the top down to position move up, then the word is written (one entry moved per cycle)
// the store RAM has one write and one read port, which sets the per-entry pace
// reset clears the fill count but not the store; entries above the count are never used
// busy is low in the done cycle, so the next word may be taken at its end
module ordered_stack_table #(
	parameter int DEPTH      = 16,
	parameter int WORD_WIDTH = 32
) (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          start,
	output logic          busy,
	input  ost_pkg::req_t req,
	output logic          done,
	output ost_pkg::rsp_t rsp
);
	import ost_pkg::*;

	localparam int AW = $clog2(DEPTH);

	logic [WORD_WIDTH-1:0] word_in;
	logic [WORD_WIDTH-1:0] rd_data;
	logic [WORD_WIDTH-1:0] ram_wdata;
	logic [AW-1:0]         ram_waddr;
	logic [AW-1:0]         ram_raddr;
	logic                  ram_we;

	// only the low WORD_WIDTH bits of the item take part
	assign word_in = WORD_WIDTH'(req.item_value);

	ost_ram #(
		.WIDTH(WORD_WIDTH),
		.DEPTH(DEPTH)
	) u_store (
		.clk  (clk),
		.we   (ram_we),
		.waddr(ram_waddr),
		.wdata(ram_wdata),
		.raddr(ram_raddr),
		.rdata(rd_data)
	);

	ost_seq #(
		.DEPTH     (DEPTH),
		.WORD_WIDTH(WORD_WIDTH)
	) u_seq (
		.clk      (clk),
		.arst_n   (arst_n),
		.start    (start),
		.req_type (req.req_type),
		.word     (word_in),
		.position (req.position),
		.busy     (busy),
		.rd_data  (rd_data),
		.ram_we   (ram_we),
		.ram_waddr(ram_waddr),
		.ram_wdata(ram_wdata),
		.ram_raddr(ram_raddr),
		.done     (done),
		.rsp      (rsp)
	);

endmodule

// ===== verif/ordered_stack_table_tb.sv =====
`timescale 1ns / 1ps
// ordered_stack_table_tb: self-checking bench for the ordered stack table.
// Shadow store predicts every response word. Depends on ost_pkg and the RTL.
module ordered_stack_table_tb;
	import ost_pkg::*;

	localparam int TABLE_DEPTH = 16;
	localparam int RANDOM_WORDS = 1300;
	localparam int STALL_LIMIT = 2000;
	localparam int DRAIN_CYCLES = 24;
	localparam logic [OP_W-1:0] OP_UNDEF = 2'd3;

	localparam int MODE_FILL = 0;
	localparam int MODE_DRAIN = 1;
	localparam int MODE_MIXED = 2;

	logic  clk;
	logic  arst_n;
	logic  start;
	logic  busy;
	req_t  req;
	logic  done;
	rsp_t  rsp;

	ordered_stack_table uut (
		.clk(clk),
		.arst_n(arst_n),
		.start(start),
		.busy(busy),
		.req(req),
		.done(done),
		.rsp(rsp)
	);

	// shadow copy of the store, plus the responses still owed
	class stack_shadow;
		logic [ITEM_W-1:0] entries [TABLE_DEPTH];
		int fill;
		rsp_t pending_rsp [$];
		int errors;
		int status_seen [4];
		int peak_fill;
		int empty_hits;

		function new();
			fill = 0;
			errors = 0;
			peak_fill = 0;
			empty_hits = 0;
			for (int i = 0; i < TABLE_DEPTH; i++) entries[i] = '0;
			for (int i = 0; i < 4; i++) status_seen[i] = 0;
		endfunction

		function void take_request(req_t r);
			rsp_t want;
			int at;
			want.status = ST_OK;
			want.item_out = '0;
			case (r.req_type)
				OP_PUSH: begin
					if (fill >= TABLE_DEPTH) begin
						want.status = ST_FULL;
					end else begin
						entries[fill] = r.item_value;
						fill++;
						want.item_out = r.item_value;
					end
				end
				OP_REMOVE: begin
					at = -1;
					for (int i = 0; i < fill; i++) begin
						if (entries[i] == r.item_value) begin
							at = i;
							break;
						end
					end
					if (at < 0) begin
						want.status = ST_NOT_FOUND;
					end else begin
						// lowest match goes, later entries close the gap
						for (int i = at; i + 1 < fill; i++) entries[i] = entries[i + 1];
						entries[fill - 1] = '0;
						fill--;
						want.item_out = r.item_value;
						if (fill == 0) empty_hits++;
					end
				end
				OP_INSERT: begin
					if (int'(r.position) >= fill) begin
						want.status = ST_BAD_POS;
					end else if (fill >= TABLE_DEPTH) begin
						want.status = ST_FULL;
					end else begin
						for (int i = fill; i > int'(r.position); i--) entries[i] = entries[i - 1];
						entries[r.position] = r.item_value;
						fill++;
						want.item_out = r.item_value;
					end
				end
				default: begin
					want.status = ST_BAD_POS;
				end
			endcase
			want.count_out = fill[COUNT_OUT_W-1:0];
			if (fill > peak_fill) peak_fill = fill;
			status_seen[want.status]++;
			pending_rsp.push_back(want);
		endfunction

		function void match_response(rsp_t got);
			rsp_t want;
			if (pending_rsp.size() == 0) begin
				$display("%0t: response word with nothing outstanding: status %0d item %h count %0d",
					$time, got.status, got.item_out, got.count_out);
				errors++;
				return;
			end
			want = pending_rsp.pop_front();
			if (got.status !== want.status) begin
				$display("%0t: status expected %0d actual %0d", $time, want.status, got.status);
				errors++;
			end
			if (got.item_out !== want.item_out) begin
				$display("%0t: item_out expected %h actual %h", $time, want.item_out, got.item_out);
				errors++;
			end
			if (got.count_out !== want.count_out) begin
				$display("%0t: count_out expected %0d actual %0d", $time, want.count_out,
					got.count_out);
				errors++;
			end
		endfunction
	endclass

	stack_shadow shadow;
	logic [ITEM_W-1:0] value_pool [8];
	int idle_pct;
	int words_sent;
	int stall_cycles = 0;

	initial clk = 1'b0;
	always #10 clk = ~clk;

	// responses cannot be held off, so every done cycle is checked
	always @(posedge clk) begin
		if (arst_n && done === 1'b1) shadow.match_response(rsp);
	end

	always @(posedge clk) begin
		if ((start && busy === 1'b0) || done === 1'b1) begin
			stall_cycles <= 0;
		end else if (stall_cycles >= STALL_LIMIT) begin
			$display("%0t: no progress for %0d cycles", $time, STALL_LIMIT);
			$display("Mismatches found");
			$finish;
		end else begin
			stall_cycles <= stall_cycles + 1;
		end
	end

	function automatic req_t make_word(logic [OP_W-1:0] op, logic [ITEM_W-1:0] val,
		logic [POS_W-1:0] pos);
		req_t r;
		r.req_type = op;
		r.item_value = val;
		r.position = pos;
		return r;
	endfunction

	// hold the word on req until the block takes it
	task automatic send_word(input req_t r);
		int gap;
		gap = 0;
		if ($urandom_range(0, 99) < idle_pct) gap = $urandom_range(1, 6);
		if (gap > 0) begin
			start <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		start <= 1'b1;
		req <= r;
		do @(posedge clk); while (busy !== 1'b0);
		shadow.take_request(r);
		words_sent++;
	endtask

	function automatic logic [ITEM_W-1:0] pick_value();
		int roll;
		roll = $urandom_range(0, 99);
		if (roll < 45) return $urandom;
		return value_pool[$urandom_range(0, 7)];
	endfunction

	function automatic req_t pick_word(int mode);
		req_t r;
		int roll;
		int push_cut;
		int insert_cut;
		int remove_cut;
		roll = $urandom_range(0, 99);
		case (mode)
			MODE_FILL: begin push_cut = 45; insert_cut = 80; remove_cut = 95; end
			MODE_DRAIN: begin push_cut = 15; insert_cut = 25; remove_cut = 95; end
			default: begin push_cut = 30; insert_cut = 55; remove_cut = 95; end
		endcase
		r.item_value = pick_value();
		r.position = POS_W'($urandom_range(0, 15));
		if (roll < push_cut) begin
			r.req_type = OP_PUSH;
		end else if (roll < insert_cut) begin
			r.req_type = OP_INSERT;
			if (shadow.fill > 0 && $urandom_range(0, 99) < 75)
				r.position = POS_W'($urandom_range(0, shadow.fill - 1));
		end else if (roll < remove_cut) begin
			r.req_type = OP_REMOVE;
			// mostly search for a word that is actually held
			if (shadow.fill > 0 && $urandom_range(0, 99) < 70)
				r.item_value = shadow.entries[$urandom_range(0, shadow.fill - 1)];
		end else begin
			r.req_type = OP_UNDEF;
		end
		return r;
	endfunction

	initial begin
		req_t directed [$];
		shadow = new();
		words_sent = 0;
		idle_pct = 19;
		arst_n <= 1'b0;
		start <= 1'b0;
		req <= '0;

		value_pool[0] = '0;
		value_pool[1] = '1;
		for (int i = 2; i < 8; i++) value_pool[i] = $urandom;

		repeat (12) @(posedge clk);
		arst_n <= 1'b1;

		// empty store corner cases, duplicates, inserts at both ends
		directed.push_back(make_word(OP_INSERT, 32'h1234_5678, 4'd0));
		directed.push_back(make_word(OP_REMOVE, 32'h0000_0000, 4'd0));
		directed.push_back(make_word(OP_UNDEF, 32'hFFFF_FFFF, 4'd15));
		directed.push_back(make_word(OP_PUSH, 32'hFFFF_FFFF, 4'd15));
		directed.push_back(make_word(OP_PUSH, 32'h0000_0000, 4'd0));
		directed.push_back(make_word(OP_PUSH, 32'hA5A5_A5A5, 4'd7));
		directed.push_back(make_word(OP_PUSH, 32'hFFFF_FFFF, 4'd0));
		directed.push_back(make_word(OP_REMOVE, 32'hFFFF_FFFF, 4'd3));
		directed.push_back(make_word(OP_INSERT, 32'h5A5A_5A5A, 4'd0));
		directed.push_back(make_word(OP_INSERT, 32'h0F0F_0F0F, 4'd2));
		directed.push_back(make_word(OP_INSERT, 32'h1111_1111, 4'd15));
		directed.push_back(make_word(OP_INSERT, 32'h2222_2222, 4'd5));
		directed.push_back(make_word(OP_INSERT, 32'h3333_3333, 4'd4));
		directed.push_back(make_word(OP_REMOVE, 32'h1234_5678, 4'd0));
		directed.push_back(make_word(OP_REMOVE, 32'h3333_3333, 4'd0));
		directed.push_back(make_word(OP_REMOVE, 32'h0000_0000, 4'd0));
		directed.push_back(make_word(OP_UNDEF, 32'h0000_0000, 4'd0));
		foreach (directed[i]) send_word(directed[i]);

		for (int k = 0; k < RANDOM_WORDS; k++) begin
			if (k == RANDOM_WORDS / 3) idle_pct = 57;
			if (k == 2 * RANDOM_WORDS / 3) idle_pct = 0;
			send_word(pick_word((k / 80) % 3));
		end
		start <= 1'b0;

		while (shadow.pending_rsp.size() != 0) @(posedge clk);
		repeat (DRAIN_CYCLES) @(posedge clk);

		$display("sent %0d words: %0d ok, %0d not found, %0d full, %0d bad position",
			words_sent, shadow.status_seen[ST_OK], shadow.status_seen[ST_NOT_FOUND],
			shadow.status_seen[ST_FULL], shadow.status_seen[ST_BAD_POS]);
		$display("store peaked at %0d entries and was drained empty %0d times",
			shadow.peak_fill, shadow.empty_hits);
		if (shadow.errors == 0) begin
			$display("No mismatches found");
		end else begin
			$display("Mismatches found");
		end
		$finish;
	end

endmodule
